### hw/rtl/spp_pkg.sv
// Shared constants, types and arithmetic helpers for the servo position controller.
package spp_pkg;

  // Angle arithmetic.
  localparam int ANGLE_COUNT = 4096;
  localparam int HALF_ANGLE  = ANGLE_COUNT / 2;

  // Integral clamp and divisor (the divisor is 2**I_DIV_SHIFT).
  localparam int INTEGRAL_LIMIT = 100000;
  localparam int I_DIV_SHIFT    = 10;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Datapath widths.
  localparam int DATA_W  = 16;
  localparam int ANG_W   = 12;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int ERR_W   = 20;
  localparam int INT_W   = 18;
  localparam int M0_W    = ERR_W + DATA_W;
  localparam int M1_W    = INT_W + DATA_W;
  localparam int M2_W    = DATA_W + DATA_W;
  localparam int SUM_W   = 40;

  // Control law codes.
  localparam logic [MODE_W-1:0] MODE_PID      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PID_MT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_P_POS    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FF       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PID_FF   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_P_SPEED  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_P_TORQUE = 3'd6;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_P_GAIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_I_GAIN      = 3'd2;
  localparam logic [IDX_W-1:0] REG_D_GAIN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPEED_GAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TORQUE_GAIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_UPPER_LIMIT = 3'd6;
  localparam logic [IDX_W-1:0] REG_LOWER_LIMIT = 3'd7;

  // Configuration register file contents.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] p_gain;
    logic signed [DATA_W-1:0] i_gain;
    logic signed [DATA_W-1:0] d_gain;
    logic signed [DATA_W-1:0] speed_gain;
    logic signed [DATA_W-1:0] torque_gain;
    logic [ANG_W-1:0]         upper_limit_angle;
    logic [ANG_W-1:0]         lower_limit_angle;
  } cfg_t;

  // One classified tick as it waits in the queue.
  typedef struct packed {
    logic                     integ;  // update the integral and use the I and D terms
    logic                     clr;    // clear the integral before this tick
    logic signed [ERR_W-1:0]  err;    // angle error of this tick, zero where unused
    logic signed [ERR_W-1:0]  mul_a;  // operand of the main product
    logic signed [DATA_W-1:0] gain;   // gain of the main product
    logic signed [DATA_W-1:0] spd;    // speed for the D term, zero where unused
    logic signed [DATA_W-1:0] ff;     // feed-forward to add, zero where unused
  } q_entry_t;

  // Shortest signed distance from b to a on the circle.
  function automatic logic signed [ERR_W-1:0] wrap_diff(input logic signed [ERR_W-1:0] a,
                                                        input logic signed [ERR_W-1:0] b);
    logic signed [ERR_W-1:0] d;
    d = a - b;
    if (d > ERR_W'(HALF_ANGLE)) begin
      return d - ERR_W'(ANGLE_COUNT);
    end else if (d < -ERR_W'(HALF_ANGLE)) begin
      return d + ERR_W'(ANGLE_COUNT);
    end
    return d;
  endfunction

  // The other way around the circle, given the short distance.
  function automatic logic signed [ERR_W-1:0] long_of(input logic signed [ERR_W-1:0] d);
    if (d > 0) begin
      return d - ERR_W'(ANGLE_COUNT);
    end
    return d + ERR_W'(ANGLE_COUNT);
  endfunction

  // Saturate a wide value to the signed 16-bit range.
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -SUM_W'(32768)) begin
      return 16'sh8000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### hw/rtl/spp_front.sv
// Front part: takes input transactions, finds the angle error and classifies the tick.
module spp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spp_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_angle,
  input  logic [spp_pkg::ANG_W-1:0]        in_measured_angle,
  input  logic signed [spp_pkg::DATA_W-1:0] in_turns_angle,
  input  logic signed [spp_pkg::DATA_W-1:0] in_measured_speed,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_speed,
  input  logic signed [spp_pkg::DATA_W-1:0] in_feedforward,
  input  logic signed [spp_pkg::DATA_W-1:0] in_measured_torque,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_torque,
  input  logic                             in_clear_integral,
  input  logic                             q_full,
  output logic                             push,
  output spp_pkg::q_entry_t                push_data
);
  import spp_pkg::*;

  logic                     f_v_r;
  logic signed [DATA_W-1:0] f_goal_angle_r;
  logic [ANG_W-1:0]         f_measured_angle_r;
  logic signed [DATA_W-1:0] f_turns_angle_r;
  logic signed [DATA_W-1:0] f_measured_speed_r;
  logic signed [DATA_W-1:0] f_goal_speed_r;
  logic signed [DATA_W-1:0] f_feedforward_r;
  logic signed [DATA_W-1:0] f_measured_torque_r;
  logic signed [DATA_W-1:0] f_goal_torque_r;
  logic                     f_clear_integral_r;

  logic                     f_adv;
  logic signed [ERR_W-1:0]  goal_s, ang_s, up_s, lo_s;
  logic signed [ERR_W-1:0]  d, up_w, lo_w, lim_up, lim_lo, lim_err;
  logic                     dir_pos, dir_neg;

  // The input register frees up when it is empty or its transaction moves on.
  assign f_adv    = !f_v_r || !q_full;
  assign in_ready = f_adv;
  assign push     = f_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_adv) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && in_valid) begin
      f_goal_angle_r      <= in_goal_angle;
      f_measured_angle_r  <= in_measured_angle;
      f_turns_angle_r     <= in_turns_angle;
      f_measured_speed_r  <= in_measured_speed;
      f_goal_speed_r      <= in_goal_speed;
      f_feedforward_r     <= in_feedforward;
      f_measured_torque_r <= in_measured_torque;
      f_goal_torque_r     <= in_goal_torque;
      f_clear_integral_r  <= in_clear_integral;
    end
  end

  // Widen the angles to a common signed width.
  assign goal_s = ERR_W'(f_goal_angle_r);
  assign ang_s  = $signed(ERR_W'(f_measured_angle_r));
  assign up_s   = $signed(ERR_W'(cfg.upper_limit_angle));
  assign lo_s   = $signed(ERR_W'(cfg.lower_limit_angle));

  // Short error and the distances to each limit in its own direction.
  always_comb begin
    d      = wrap_diff(goal_s, ang_s);
    up_w   = wrap_diff(up_s, ang_s);
    lo_w   = wrap_diff(lo_s, ang_s);
    lim_up = (up_w < 0) ? long_of(up_w) : up_w;
    lim_lo = (lo_w > 0) ? long_of(lo_w) : lo_w;
  end

  // Direction choice: the short way unless it would cross a limit.
  always_comb begin
    dir_pos = 1'b0;
    dir_neg = 1'b0;
    if (up_s == lo_s || ang_s >= ERR_W'(ANGLE_COUNT)) begin
      dir_pos = 1'b0;
    end else if (goal_s == up_s) begin
      dir_pos = 1'b1;
    end else if (goal_s == lo_s) begin
      dir_neg = 1'b1;
    end else if (d > 0) begin
      dir_pos = (d <= lim_up);
      dir_neg = !(d <= lim_up);
    end else if (d < 0) begin
      dir_neg = (d >= lim_lo);
      dir_pos = !(d >= lim_lo);
    end
    lim_err = ((dir_pos && d < 0) || (dir_neg && d > 0)) ? long_of(d) : d;
  end

  // Classify the tick by control law.
  always_comb begin
    push_data       = '0;
    push_data.clr   = f_clear_integral_r;
    unique case (cfg.mode) inside
      MODE_PID, MODE_PID_FF: begin
        push_data.integ = 1'b1;
        push_data.err   = lim_err;
        push_data.mul_a = lim_err;
        push_data.gain  = cfg.p_gain;
        push_data.spd   = f_measured_speed_r;
        push_data.ff    = (cfg.mode == MODE_PID_FF) ? f_feedforward_r : '0;
      end
      MODE_PID_MT: begin
        push_data.integ = 1'b1;
        push_data.err   = ERR_W'(f_goal_angle_r) - ERR_W'(f_turns_angle_r);
        push_data.mul_a = ERR_W'(f_goal_angle_r) - ERR_W'(f_turns_angle_r);
        push_data.gain  = cfg.p_gain;
        push_data.spd   = f_measured_speed_r;
      end
      MODE_P_POS: begin
        push_data.err   = lim_err;
        push_data.mul_a = lim_err;
        push_data.gain  = cfg.p_gain;
      end
      MODE_FF: begin
        push_data.ff = f_feedforward_r;
      end
      MODE_P_SPEED: begin
        push_data.mul_a = ERR_W'(f_goal_speed_r) - ERR_W'(f_measured_speed_r);
        push_data.gain  = cfg.speed_gain;
      end
      MODE_P_TORQUE: begin
        push_data.mul_a = ERR_W'(f_goal_torque_r) - ERR_W'(f_measured_torque_r);
        push_data.gain  = cfg.torque_gain;
      end
      default: begin
        push_data.integ = 1'b0;
      end
    endcase
  end

  // A transaction held against a full queue stays in place.
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v_r && q_full) |=> (f_v_r && $stable(f_goal_angle_r) && $stable(f_clear_integral_r)))
    else $error("front transaction lost while queue full");

endmodule

### hw/rtl/spp_queue.sv
// Short queue of classified ticks between the front and back parts.
module spp_queue #(
  parameter int DEPTH = spp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spp_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output spp_pkg::q_entry_t pop_data,
  output logic              empty
);
  import spp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty with unequal pointers");

endmodule

### hw/rtl/spp_back.sv
// Back part: integral update, gain products, sum and saturation into the output register.
module spp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spp_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  spp_pkg::q_entry_t                 q_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spp_pkg::DATA_W-1:0] out_drive_command,
  output logic signed [spp_pkg::DATA_W-1:0] out_angle_error
);
  import spp_pkg::*;

  localparam int ISUM_W = ERR_W + 1;
  localparam logic signed [INT_W-1:0] LIM_POS  = INT_W'(INTEGRAL_LIMIT);
  localparam logic signed [INT_W-1:0] LIM_NEG  = -INT_W'(INTEGRAL_LIMIT);
  localparam logic signed [M1_W-1:0]  DIV_BIAS = M1_W'((1 << I_DIV_SHIFT) - 1);

  logic                      en;
  logic signed [INT_W-1:0]   integral_r, integral_nxt, int_base;
  logic signed [ISUM_W-1:0]  int_sum;

  logic                      s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic                      s1_integ_r;
  logic signed [INT_W-1:0]   s1_ival_r;
  logic signed [ERR_W-1:0]   s1_mul_a_r;
  logic signed [DATA_W-1:0]  s1_gain_r, s1_spd_r, s1_ff_r, s1_err_r;
  logic signed [M0_W-1:0]    s2_m0_r;
  logic signed [M1_W-1:0]    s2_m1_r, m1_adj;
  logic signed [M2_W-1:0]    s2_m2_r;
  logic signed [DATA_W-1:0]  s2_ff_r, s2_err_r;
  logic signed [SUM_W-1:0]   s3_sum_r, total;
  logic signed [M1_W-1:0]    s3_q_r;
  logic signed [DATA_W-1:0]  s3_ff_r, s3_err_r;
  logic signed [DATA_W-1:0]  out_cmd_r, out_err_r;

  // The whole back pipeline advances unless the output register is stalled.
  assign en  = !out_v_r || out_ready;
  assign pop = en && !q_empty;

  // Integral update with clear and clamp.
  always_comb begin
    int_base = q_data.clr ? '0 : integral_r;
    int_sum  = ISUM_W'(int_base) + ISUM_W'(q_data.err);
    if (!q_data.integ) begin
      integral_nxt = int_base;
    end else if (int_sum > ISUM_W'(LIM_POS)) begin
      integral_nxt = LIM_POS;
    end else if (int_sum < ISUM_W'(LIM_NEG)) begin
      integral_nxt = LIM_NEG;
    end else begin
      integral_nxt = int_sum[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
    end else if (pop) begin
      integral_r <= integral_nxt;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= !q_empty;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // Stage 1: capture the entry and the integral it produced.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_integ_r <= q_data.integ;
      s1_ival_r  <= integral_nxt;
      s1_mul_a_r <= q_data.mul_a;
      s1_gain_r  <= q_data.gain;
      s1_spd_r   <= q_data.spd;
      s1_ff_r    <= q_data.ff;
      s1_err_r   <= sat16(SUM_W'(q_data.err));
    end
  end

  // Stage 2: the three gain products.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_m0_r  <= M0_W'(s1_mul_a_r) * M0_W'(s1_gain_r);
      s2_m1_r  <= s1_integ_r ? M1_W'(s1_ival_r) * M1_W'(cfg.i_gain) : '0;
      s2_m2_r  <= M2_W'(s1_spd_r) * M2_W'(cfg.d_gain);
      s2_ff_r  <= s1_ff_r;
      s2_err_r <= s1_err_r;
    end
  end

  // Integral term divided by the power-of-two divisor, rounding toward zero.
  always_comb begin
    if (s2_m1_r < 0) begin
      m1_adj = s2_m1_r + DIV_BIAS;
    end else begin
      m1_adj = s2_m1_r;
    end
  end

  // Stage 3: quotient and partial sum.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_q_r   <= m1_adj >>> I_DIV_SHIFT;
      s3_sum_r <= SUM_W'(s2_m0_r) + SUM_W'(s2_m2_r);
      s3_ff_r  <= s2_ff_r;
      s3_err_r <= s2_err_r;
    end
  end

  assign total = s3_sum_r + SUM_W'(s3_q_r) + SUM_W'(s3_ff_r);

  // Output register: final sum saturated to 16 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      out_cmd_r <= sat16(total);
      out_err_r <= s3_err_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_drive_command = out_cmd_r;
  assign out_angle_error   = out_err_r;

  a_integral_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integral_r <= LIM_POS) && (integral_r >= LIM_NEG))
    else $error("integral outside its clamp");

  a_clear_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_data.clr && !q_data.integ) |=> (integral_r == '0))
    else $error("integral not cleared");

endmodule

### hw/rtl/servo_position_pid_with_angle_limits.sv
// Top level of the servo position controller: configuration registers and part wiring.
//
// Usage:
//   One input transaction on the in_ channel is one control tick; it gives exactly
//   one result transaction on the out_ channel (drive_command, angle_error), in order.
//   Configuration is written on the cfg_ channel (index 0 mode, 1..5 gains,
//   6 upper limit, 7 lower limit); cfg_ready is always high. Write it only while
//   no tick is in flight.
//   Path: a result passes through the input register, the queue, the integral
//   stage, the product stage, the sum stage and the output register.
//   Throughput: one tick per cycle; the integral update is a combinational
//   add-and-clamp loop, so nothing limits the rate while out_ready stays high.
//   Reset: all configuration registers, the integral and every valid bit clear;
//   the queue starts empty.
//   Stall: when out_ready is low with a result waiting, the output register holds
//   it, the back pipeline freezes, the queue fills, and in_ready drops once the
//   queue and the input register are both full.
module servo_position_pid_with_angle_limits #(
  parameter int QUEUE_DEPTH = spp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [spp_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_angle,
  input  logic [spp_pkg::ANG_W-1:0]         in_measured_angle,
  input  logic signed [spp_pkg::DATA_W-1:0] in_turns_angle,
  input  logic signed [spp_pkg::DATA_W-1:0] in_measured_speed,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_speed,
  input  logic signed [spp_pkg::DATA_W-1:0] in_feedforward,
  input  logic signed [spp_pkg::DATA_W-1:0] in_measured_torque,
  input  logic signed [spp_pkg::DATA_W-1:0] in_goal_torque,
  input  logic                              in_clear_integral,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spp_pkg::DATA_W-1:0] out_drive_command,
  output logic signed [spp_pkg::DATA_W-1:0] out_angle_error
);
  import spp_pkg::*;

  cfg_t     cfg_r;
  q_entry_t push_data, pop_data;
  logic     push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:        cfg_r.mode              <= cfg_data[MODE_W-1:0];
        REG_P_GAIN:      cfg_r.p_gain            <= cfg_data;
        REG_I_GAIN:      cfg_r.i_gain            <= cfg_data;
        REG_D_GAIN:      cfg_r.d_gain            <= cfg_data;
        REG_SPEED_GAIN:  cfg_r.speed_gain        <= cfg_data;
        REG_TORQUE_GAIN: cfg_r.torque_gain       <= cfg_data;
        REG_UPPER_LIMIT: cfg_r.upper_limit_angle <= cfg_data[ANG_W-1:0];
        REG_LOWER_LIMIT: cfg_r.lower_limit_angle <= cfg_data[ANG_W-1:0];
        default:         cfg_r                   <= cfg_r;
      endcase
    end
  end

  spp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_goal_angle      (in_goal_angle),
    .in_measured_angle  (in_measured_angle),
    .in_turns_angle     (in_turns_angle),
    .in_measured_speed  (in_measured_speed),
    .in_goal_speed      (in_goal_speed),
    .in_feedforward     (in_feedforward),
    .in_measured_torque (in_measured_torque),
    .in_goal_torque     (in_goal_torque),
    .in_clear_integral  (in_clear_integral),
    .q_full             (q_full),
    .push               (push),
    .push_data          (push_data)
  );

  spp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  spp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_command (out_drive_command),
    .out_angle_error   (out_angle_error)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the servo position controller with angle limits.
module testbench;
  import spp_pkg::*;

  // Mode code with no control law behind it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // One control tick as offered on the input channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] goal_angle;
    logic [ANG_W-1:0]         measured_angle;
    logic signed [DATA_W-1:0] turns_angle;
    logic signed [DATA_W-1:0] measured_speed;
    logic signed [DATA_W-1:0] goal_speed;
    logic signed [DATA_W-1:0] feedforward;
    logic signed [DATA_W-1:0] measured_torque;
    logic signed [DATA_W-1:0] goal_torque;
    logic                     clear_integral;
  } tick_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] drive_command;
    logic signed [DATA_W-1:0] angle_error;
  } result_t;

  // One row of the directed table; a typed-in result is used where given.
  typedef struct {
    int      setting;
    tick_t   stim;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_goal_angle = '0;
  logic [ANG_W-1:0] in_measured_angle = '0;
  logic signed [DATA_W-1:0] in_turns_angle = '0;
  logic signed [DATA_W-1:0] in_measured_speed = '0;
  logic signed [DATA_W-1:0] in_goal_speed = '0;
  logic signed [DATA_W-1:0] in_feedforward = '0;
  logic signed [DATA_W-1:0] in_measured_torque = '0;
  logic signed [DATA_W-1:0] in_goal_torque = '0;
  logic in_clear_integral = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_drive_command;
  logic signed [DATA_W-1:0] out_angle_error;

  // Controller state as the predictor sees it.
  cfg_t regs = '0;
  longint integral_acc = 0;

  result_t pending_results[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int burst_left = 0;
  logic hold_off = 1'b0;
  int stall_pct = 0;
  int stall_span = 0;

  servo_position_pid_with_angle_limits dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_goal_angle     (in_goal_angle),
    .in_measured_angle (in_measured_angle),
    .in_turns_angle    (in_turns_angle),
    .in_measured_speed (in_measured_speed),
    .in_goal_speed     (in_goal_speed),
    .in_feedforward    (in_feedforward),
    .in_measured_torque(in_measured_torque),
    .in_goal_torque    (in_goal_torque),
    .in_clear_integral (in_clear_integral),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_command (out_drive_command),
    .out_angle_error   (out_angle_error)
  );

  always #10 clk = ~clk;

  // Shortest signed distance from b to a around the circle.
  function automatic longint short_way(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d > HALF_ANGLE) return d - ANGLE_COUNT;
    if (d < -HALF_ANGLE) return d + ANGLE_COUNT;
    return d;
  endfunction

  // The other way around the circle.
  function automatic longint long_way(input longint a, input longint b);
    longint d;
    d = short_way(a, b);
    return (d > 0) ? d - ANGLE_COUNT : d + ANGLE_COUNT;
  endfunction

  // Direction forced by the angle limits: +1, -1, or 0 for no constraint.
  function automatic int travel_dir(input longint goal, input longint ang);
    longint d;
    longint lim;
    longint up;
    longint lo;
    up = longint'(regs.upper_limit_angle);
    lo = longint'(regs.lower_limit_angle);
    if (up == lo || ang >= ANGLE_COUNT) return 0;
    if (goal == up) return 1;
    if (goal == lo) return -1;
    d = short_way(goal, ang);
    if (d == 0) return 0;
    if (d > 0) begin
      lim = short_way(up, ang);
      if (lim < 0) lim = long_way(up, ang);
      return (d <= lim) ? 1 : -1;
    end
    lim = short_way(lo, ang);
    if (lim > 0) lim = long_way(lo, ang);
    return (d >= lim) ? -1 : 1;
  endfunction

  // Angle error after the limit check picks the way around.
  function automatic longint aimed_error(input longint goal, input longint ang);
    longint e;
    int dir;
    e = short_way(goal, ang);
    dir = travel_dir(goal, ang);
    if (dir != 0 && e * dir < 0) e = long_way(goal, ang);
    return e;
  endfunction

  function automatic logic signed [DATA_W-1:0] saturate16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[DATA_W-1:0];
  endfunction

  // Computes the result of one tick and advances the integral.
  function automatic result_t control_tick(input tick_t t);
    longint goal;
    longint spd;
    longint err;
    longint cmd;
    result_t r;
    goal = t.goal_angle;
    spd = t.measured_speed;
    err = 0;
    cmd = 0;
    if (t.clear_integral) integral_acc = 0;
    case (regs.mode)
      MODE_PID, MODE_PID_MT, MODE_PID_FF: begin
        if (regs.mode == MODE_PID_MT) err = goal - longint'(t.turns_angle);
        else err = aimed_error(goal, longint'(t.measured_angle));
        integral_acc += err;
        if (integral_acc > INTEGRAL_LIMIT) integral_acc = INTEGRAL_LIMIT;
        else if (integral_acc < -INTEGRAL_LIMIT) integral_acc = -INTEGRAL_LIMIT;
        cmd = err * regs.p_gain
            + (integral_acc * regs.i_gain) / (longint'(1) << I_DIV_SHIFT)
            + spd * regs.d_gain;
        if (regs.mode == MODE_PID_FF) cmd += longint'(t.feedforward);
      end
      MODE_P_POS: begin
        err = aimed_error(goal, longint'(t.measured_angle));
        cmd = err * regs.p_gain;
      end
      MODE_FF: cmd = longint'(t.feedforward);
      MODE_P_SPEED: cmd = (longint'(t.goal_speed) - spd) * regs.speed_gain;
      MODE_P_TORQUE: begin
        cmd = (longint'(t.goal_torque) - longint'(t.measured_torque)) * regs.torque_gain;
      end
      default: ;
    endcase
    r.drive_command = saturate16(cmd);
    r.angle_error = saturate16(err);
    return r;
  endfunction

  function automatic cfg_t make_cfg(input logic [MODE_W-1:0] mode, input int p, input int i,
                                    input int d, input int s, input int q, input int up,
                                    input int lo);
    cfg_t c;
    c.mode = mode;
    c.p_gain = 16'(p);
    c.i_gain = 16'(i);
    c.d_gain = 16'(d);
    c.speed_gain = 16'(s);
    c.torque_gain = 16'(q);
    c.upper_limit_angle = 12'(up);
    c.lower_limit_angle = 12'(lo);
    return c;
  endfunction

  function automatic directed_row_t dir_row(input int setting, input int goal, input int ang,
                                           input int turns, input int spd, input int gspd,
                                           input int ff, input int trq, input int gtrq,
                                           input bit clr, input bit typed, input int cmd,
                                           input int err);
    directed_row_t r;
    r.setting = setting;
    r.stim = '{16'(goal), 12'(ang), 16'(turns), 16'(spd), 16'(gspd), 16'(ff), 16'(trq),
               16'(gtrq), clr};
    r.typed = typed;
    r.want = '{16'(cmd), 16'(err)};
    return r;
  endfunction

  // Random 16-bit value with the extremes and zero weighted in.
  function automatic logic signed [DATA_W-1:0] any16();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 128)) - 64;
      default: return any16();
    endcase
  endfunction

  // Writes all eight registers; unused data bits carry random values.
  task automatic apply_settings(input cfg_t s);
    logic [DATA_W-1:0] data;
    for (int k = 0; k < 8; k++) begin
      data = 16'($urandom());
      case (IDX_W'(k))
        REG_MODE:        data[MODE_W-1:0] = s.mode;
        REG_P_GAIN:      data = s.p_gain;
        REG_I_GAIN:      data = s.i_gain;
        REG_D_GAIN:      data = s.d_gain;
        REG_SPEED_GAIN:  data = s.speed_gain;
        REG_TORQUE_GAIN: data = s.torque_gain;
        REG_UPPER_LIMIT: data[ANG_W-1:0] = s.upper_limit_angle;
        REG_LOWER_LIMIT: data[ANG_W-1:0] = s.lower_limit_angle;
        default: ;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= IDX_W'(k);
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    regs = s;
  endtask

  // Offers one tick in bursts with random gaps and records its expected result.
  task automatic offer_tick(input tick_t t, input bit typed, input result_t want);
    result_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_goal_angle <= t.goal_angle;
    in_measured_angle <= t.measured_angle;
    in_turns_angle <= t.turns_angle;
    in_measured_speed <= t.measured_speed;
    in_goal_speed <= t.goal_speed;
    in_feedforward <= t.feedforward;
    in_measured_torque <= t.measured_torque;
    in_goal_torque <= t.goal_torque;
    in_clear_integral <= t.clear_integral;
    do @(posedge clk); while (!in_ready);
    predicted = control_tick(t);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: stalls at random with a stall percentage redrawn from a fixed set, and checks each transaction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: drive_command %0d, angle_error %0d",
               out_drive_command, out_angle_error);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_drive_command !== want.drive_command) begin
          $error("drive_command mismatch: expected %0d, actual %0d",
                 want.drive_command, out_drive_command);
          mismatches++;
        end
        if (out_angle_error !== want.angle_error) begin
          $error("angle_error mismatch: expected %0d, actual %0d",
                 want.angle_error, out_angle_error);
          mismatches++;
        end
      end
    end
    if (stall_span == 0) begin
      stall_span = 64;
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
    end
    stall_span--;
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // One long receiver hold-off in the middle of a random phase, while ticks keep coming.
  initial begin
    wait (ticks_sent >= 460);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // Main stimulus: reset, directed table, then random phases.
  initial begin
    directed_row_t directed[$];
    cfg_t dir_cfg[9];
    cfg_t phase_cfg;
    tick_t t;
    logic [MODE_W-1:0] mode_plan[8];
    int cur_setting;
    int run_left;
    int aim;
    int lean;
    int spread;
    int up;
    int lo;

    dir_cfg[0] = '0;
    dir_cfg[1] = make_cfg(MODE_PID, 32767, 0, 0, 0, 0, 1000, 3000);
    dir_cfg[2] = make_cfg(MODE_PID_FF, -32768, 32767, -1, 0, 0, 4095, 0);
    dir_cfg[3] = make_cfg(MODE_PID_MT, 1, -32768, 32767, 0, 0, 0, 4095);
    dir_cfg[4] = make_cfg(MODE_P_POS, 3, 500, 7, 0, 0, 2048, 2048);
    dir_cfg[5] = make_cfg(MODE_FF, 5, 5, 5, 5, 5, 100, 200);
    dir_cfg[6] = make_cfg(MODE_P_SPEED, 0, 0, 0, -32768, 0, 0, 0);
    dir_cfg[7] = make_cfg(MODE_P_TORQUE, 0, 0, 0, 0, 32767, 0, 0);
    dir_cfg[8] = make_cfg(MODE_UNUSED, 1000, 1000, 1000, 1000, 1000, 10, 20);

    // Reset values: all gains zero and wheel mode, so only the short error shows.
    directed.push_back(dir_row(0, 100, 0, 0, 999, 0, 0, 0, 0, 0, 1, 0, 100));
    directed.push_back(dir_row(0, -32768, 4095, 0, 0, 0, 0, 0, 0, 0, 1, 0, -32767));
    directed.push_back(dir_row(0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 28671));
    // Limits 1000 and 3000: zero error, blocked short path, and goals on each limit.
    directed.push_back(dir_row(1, 2000, 2000, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    directed.push_back(dir_row(1, 1500, 1000, 0, 0, 0, 0, 0, 0, 0, 1, -32768, -3596));
    directed.push_back(dir_row(1, 1000, 3500, 0, 0, 0, 0, 0, 0, 0, 1, 32767, 1596));
    directed.push_back(dir_row(1, 3000, 2000, 0, 0, 0, 0, 0, 0, 0, 1, -32768, -3096));
    directed.push_back(dir_row(1, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // PID plus feed-forward with limits at the ends of the range.
    directed.push_back(dir_row(2, 0, 4095, 0, 32767, 0, -32768, 0, 0, 1, 0, 0, 0));
    directed.push_back(dir_row(2, 4095, 0, 0, -32768, 0, 32767, 0, 0, 0, 0, 0, 0));
    directed.push_back(dir_row(2, 2048, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(dir_row(2, -1, 2048, 0, -1, 0, 1, 0, 0, 1, 0, 0, 0));
    // Multi-turn: the widest errors drive the integral into its clamp both ways.
    directed.push_back(dir_row(3, 32767, 0, -32768, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(dir_row(3, 32767, 0, -32768, -3, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(dir_row(3, -32768, 0, 32767, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(dir_row(3, -32768, 0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // P on position in wheel mode, including the half-turn boundary.
    directed.push_back(dir_row(4, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(dir_row(4, 0, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Feed-forward only, speed and torque loops, and the unused mode code.
    directed.push_back(dir_row(5, 5, 9, 0, 0, 0, -32768, 0, 0, 0, 1, -32768, 0));
    directed.push_back(dir_row(5, 5, 9, 0, 0, 0, 32767, 0, 0, 0, 1, 32767, 0));
    directed.push_back(dir_row(6, 0, 0, 0, 32767, -32768, 0, 0, 0, 0, 1, 32767, 0));
    directed.push_back(dir_row(6, 0, 0, 0, 77, 77, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(dir_row(7, 0, 0, 0, 0, 0, 0, -32768, 32767, 0, 1, 32767, 0));
    directed.push_back(dir_row(7, 0, 0, 0, 0, 0, 0, 32767, -32768, 0, 1, -32768, 0));
    directed.push_back(dir_row(8, 1234, 17, 50, 50, 60, 70, 80, 90, 0, 1, 0, 0));

    mode_plan = '{MODE_PID, MODE_PID_FF, MODE_PID_MT, MODE_P_POS, MODE_FF, MODE_P_SPEED,
                  MODE_P_TORQUE, MODE_PID_MT};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the settings are rewritten only when a row asks for a new set.
    cur_setting = 0;
    foreach (directed[r]) begin
      if (directed[r].setting != cur_setting) begin
        wait_drained();
        apply_settings(dir_cfg[directed[r].setting]);
        cur_setting = directed[r].setting;
      end
      offer_tick(directed[r].stim, directed[r].typed, directed[r].want);
    end

    // Random phases: runs that hold a goal with a steady lean build up the integral.
    run_left = 0;
    aim = 0;
    lean = 0;
    for (int ph = 0; ph < 8; ph++) begin
      up = $urandom_range(0, 4095);
      lo = ($urandom_range(3) == 0) ? up : $urandom_range(0, 4095);
      if (ph == 0) phase_cfg = make_cfg(mode_plan[ph], 32767, 32767, 32767, 32767, 32767,
                                        4095, 0);
      else if (ph == 1) phase_cfg = make_cfg(mode_plan[ph], -32768, -32768, -32768, -32768,
                                             -32768, 0, 4095);
      else phase_cfg = make_cfg(mode_plan[ph], rand_gain(), rand_gain(), rand_gain(),
                                rand_gain(), rand_gain(), up, lo);
      up = phase_cfg.upper_limit_angle;
      lo = phase_cfg.lower_limit_angle;
      wait_drained();
      apply_settings(phase_cfg);
      run_left = 0;
      for (int n = 0; n < 125; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(10, 60);
          aim = $urandom_range(0, 4095);
          if ($urandom_range(3) == 0) aim = $urandom_range(1) ? up : lo;
          spread = $urandom_range(1) ? 64 : 2047;
          lean = int'($urandom_range(0, 2 * spread)) - spread;
        end
        run_left--;
        t.goal_angle = 16'(aim);
        t.measured_angle = 12'(aim - lean + int'($urandom_range(0, 32)) - 16);
        t.turns_angle = 16'(aim - 8 * lean);
        if ($urandom_range(15) == 0) t.goal_angle = any16();
        if ($urandom_range(15) == 0) t.measured_angle = 12'($urandom());
        if ($urandom_range(15) == 0) t.turns_angle = any16();
        t.measured_speed = any16();
        t.goal_speed = any16();
        t.feedforward = any16();
        t.measured_torque = any16();
        t.goal_torque = any16();
        t.clear_integral = ($urandom_range(19) == 0);
        offer_tick(t, 1'b0, '0);
      end
    end

    // Let any stray result show up after the last expected one.
    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
